// ===== design/nss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nss_pkg
// Shared types, character constants and helpers for the name sanitiser.
// ----------------------------------------------------------------------------
package nss_pkg;

  localparam logic [7:0] SEP_CHAR   = 8'h5F;  // '_'
  localparam logic [7:0] SPACE_CHAR = 8'h20;  // ' '
  localparam logic [7:0] DASH_CHAR  = 8'h2D;  // '-'
  localparam logic [7:0] DOT_CHAR   = 8'h2E;  // '.'

  localparam int UNNAMED_LEN = 7;
  localparam int STEP_W      = $clog2(UNNAMED_LEN);
  localparam logic [STEP_W-1:0] UNNAMED_LAST = STEP_W'(UNNAMED_LEN - 1);

  // What the back end has to emit for one queued command.
  typedef enum logic [1:0] {
    CMD_BYTES,    // byte_a, then '_' when two is set; never the last word
    CMD_LAST,     // byte_a as the final word of the name
    CMD_UNNAMED   // the fallback reply for an empty name
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  byte_a;
    logic        two;
  } cmd_t;

  function automatic logic is_text(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h41) && (c <= 8'h5A)) ||
        ((c >= 8'h61) && (c <= 8'h7A)) ||
        ((c >= 8'h30) && (c <= 8'h39)) ||
        (c == DASH_CHAR) || (c == DOT_CHAR);
    return r;
  endfunction

  function automatic logic [7:0] unnamed_char(input logic [STEP_W-1:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h75;  // u
      3'd1:    r = 8'h6E;  // n
      3'd2:    r = 8'h6E;  // n
      3'd3:    r = 8'h61;  // a
      3'd4:    r = 8'h6D;  // m
      3'd5:    r = 8'h65;  // e
      3'd6:    r = 8'h64;  // d
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/name_sanitiser_stream.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// name_sanitiser_stream
// Cleans up a streamed name into a safe identifier of ASCII text bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one word per raw byte of a name (s_tdata) and one
//   closing word with s_tlast high, whose data is ignored. The master side
//   gives the cleaned name, one byte per word, with m_tlast on its final byte.
//   Letters, digits, '-' and '.' pass, spaces and underscores fold into a
//   single '_' between text, everything else is dropped. An empty result is
//   answered with "unnamed".
//   The newest text byte is held back until the next text byte or the closing
//   word arrives, so output lags input by one text byte. Once a word releases
//   output, its first word passes through the command queue and the output
//   register before it reaches the master side. The back end sends one word per
//   cycle while the receiver is ready; a text byte can release two words. Input
//   words are taken every cycle while the four-entry command queue has room.
//   When the receiver stalls, the output register holds its word and the
//   queue fills; s_tready falls only when the queue is full.
//   Reset clears the name state, the queue and the output valid; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module name_sanitiser_stream #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // end_of_name
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast    // last_of_name
);
  import nss_pkg::*;

  logic fire;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  cmd_t push_cmd;
  cmd_t head;

  // The front end never needs to wait for anything but room in the queue.
  assign s_tready = !q_full;
  assign fire     = s_tvalid && s_tready;

  nss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .in_byte     (s_tdata),
    .end_of_name (s_tlast),
    .push        (push),
    .cmd         (push_cmd)
  );

  nss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  nss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== design/nss_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nss_front
// Classifies incoming words, keeps the name state and issues emit commands.
// ----------------------------------------------------------------------------
module nss_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire logic [7:0]    in_byte,
  input  wire logic          end_of_name,
  output logic               push,
  output nss_pkg::cmd_t      cmd
);
  import nss_pkg::*;

  logic       pending_separator;
  logic       seen_text;
  logic [7:0] held_byte;
  logic       held_valid;

  logic text_in;
  logic sep_in;

  assign text_in = is_text(in_byte);
  assign sep_in  = (in_byte == SEP_CHAR) || (in_byte == SPACE_CHAR);

  // An end word always produces output; a text word only when a byte is held.
  always_comb begin
    push       = 1'b0;
    cmd.kind   = CMD_BYTES;
    cmd.byte_a = held_byte;
    cmd.two    = 1'b0;
    if (end_of_name) begin
      push     = fire;
      cmd.kind = held_valid ? CMD_LAST : CMD_UNNAMED;
    end else if (text_in) begin
      push       = fire && (held_valid || pending_separator);
      cmd.byte_a = held_valid ? held_byte : SEP_CHAR;
      cmd.two    = held_valid && pending_separator;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_separator <= 1'b0;
      seen_text         <= 1'b0;
      held_valid        <= 1'b0;
      held_byte         <= 8'h00;
    end else if (fire) begin
      if (end_of_name) begin
        pending_separator <= 1'b0;
        seen_text         <= 1'b0;
        held_valid        <= 1'b0;
        held_byte         <= 8'h00;
      end else if (text_in) begin
        pending_separator <= 1'b0;
        seen_text         <= 1'b1;
        held_valid        <= 1'b1;
        held_byte         <= in_byte;
      end else if (sep_in && seen_text) begin
        pending_separator <= 1'b1;
      end
    end
  end

  // A held byte exists exactly when text has been seen in this name.
  assert property (@(posedge clk) disable iff (rst) held_valid == seen_text)
    else $error("nss_front: held_valid and seen_text disagree");

  // A separator is only remembered after text.
  assert property (@(posedge clk) disable iff (rst) pending_separator |-> seen_text)
    else $error("nss_front: separator pending before any text");

  // Every end word issues a command.
  assert property (@(posedge clk) disable iff (rst) (fire && end_of_name) |-> push)
    else $error("nss_front: end word did not issue a command");

endmodule
`default_nettype wire

// ===== design/nss_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nss_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module nss_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire nss_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output nss_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);
  import nss_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("nss_queue: count beyond depth");

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("nss_queue: push into full queue");

  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("nss_queue: pop from empty queue");

endmodule
`default_nettype wire

// ===== design/nss_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nss_back
// Expands queued commands into output words through a registered output stage.
// ----------------------------------------------------------------------------
module nss_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire nss_pkg::cmd_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tlast
);
  import nss_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] final_step;
  logic              load;
  logic [7:0]        word_byte;
  logic              word_last;

  assign load = !empty && (!m_tvalid || m_tready);
  assign pop  = load && (step == final_step);

  always_comb begin
    final_step = '0;
    word_byte  = head.byte_a;
    word_last  = 1'b0;
    unique case (head.kind)
      CMD_BYTES: begin
        final_step = head.two ? STEP_W'(1) : '0;
        word_byte  = (step == '0) ? head.byte_a : SEP_CHAR;
      end
      CMD_LAST: begin
        word_last = 1'b1;
      end
      CMD_UNNAMED: begin
        final_step = UNNAMED_LAST;
        word_byte  = unnamed_char(step);
        word_last  = (step == UNNAMED_LAST);
      end
      default: begin
        final_step = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        step     <= pop ? '0 : step + STEP_W'(1);
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= word_byte;
      m_tlast <= word_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) step <= UNNAMED_LAST)
    else $error("nss_back: step counter out of range");

  assert property (@(posedge clk) disable iff (rst) (step != '0) |-> !empty)
    else $error("nss_back: command left while partly emitted");

  assert property (@(posedge clk) disable iff (rst) (load && word_last) |-> pop)
    else $error("nss_back: last word without retiring its command");

endmodule
`default_nettype wire

// ===== dv/name_sanitiser_stream_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_sanitiser_stream_tb
// Self-checking bench for the streamed name sanitiser.
// ----------------------------------------------------------------------------
// Raw name bytes go into the slave side, and each name is closed by a word
// with s_tlast high. A scoreboard object keeps its own copy of the cleanup
// state. For every accepted input word it works out the bytes that the block
// must release. Each word taken on the master side is checked against the
// oldest of those bytes.
//
// The run starts with a short directed set of names that covers the corner
// cases. These are junk bytes, separators before any text, runs of
// separators, a trailing separator, an empty name and a name made only of
// separators and junk. After that come random names in three idling phases,
// in this order: a sender that rarely idles with a receiver that often
// stalls, the other way round, and no idling at all. Between phases the
// sender holds off until every expected byte has come out.
// ----------------------------------------------------------------------------
module name_sanitiser_stream_tb;
  import nss_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_WORDS    = 150;

  // One byte of the cleaned name as it should appear on the master side.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_name;
  } name_word_t;

  // Tracks the cleanup state of the name in flight and the bytes still owed.
  class name_scoreboard;
    logic [7:0]  held_char;
    logic        held_present;
    logic        sep_owed;
    logic        text_started;
    name_word_t  expected_words[$];
    int          fail_count;

    function new();
      clear_name();
      fail_count = 0;
    endfunction

    static function logic is_name_char(logic [7:0] c);
      return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) ||
             (c == DASH_CHAR) || (c == DOT_CHAR);
    endfunction

    static function logic is_separator(logic [7:0] c);
      return (c == SEP_CHAR) || (c == SPACE_CHAR);
    endfunction

    function void clear_name();
      held_char    = 8'h00;
      held_present = 1'b0;
      sep_owed     = 1'b0;
      text_started = 1'b0;
    endfunction

    function void owe(logic [7:0] b, logic last);
      name_word_t w;
      w.out_byte     = b;
      w.last_of_name = last;
      expected_words = {expected_words, w};
    endfunction

    // Called for every word accepted on the slave side.
    function void absorb_word(logic [7:0] b, logic end_of_name);
      logic [7:0] fallback[7];
      fallback = '{8'h75, 8'h6E, 8'h6E, 8'h61, 8'h6D, 8'h65, 8'h64};
      if (end_of_name) begin
        if (held_present) begin
          owe(held_char, 1'b1);
        end else begin
          foreach (fallback[i]) owe(fallback[i], i == 6);
        end
        clear_name();
      end else if (is_name_char(b)) begin
        if (held_present) owe(held_char, 1'b0);
        if (sep_owed) owe(SEP_CHAR, 1'b0);
        held_char    = b;
        held_present = 1'b1;
        text_started = 1'b1;
        sep_owed     = 1'b0;
      end else if (is_separator(b) && text_started) begin
        sep_owed = 1'b1;
      end
    endfunction

    // Called for every word accepted on the master side.
    function void check_word(logic [7:0] b, logic last);
      name_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte=%h last_of_name=%b", b, last);
        fail_count++;
        return;
      end
      w = expected_words.pop_front();
      if (b !== w.out_byte) begin
        $error("out_byte: expected %h, got %h", w.out_byte, b);
        fail_count++;
      end
      if (last !== w.last_of_name) begin
        $error("last_of_name: expected %b, got %b", w.last_of_name, last);
        fail_count++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_tlast  = 1'b0;   // end_of_name
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // last_of_name

  name_scoreboard sb;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int sent_words    = 0;
  int stall_cycles  = 0;

  name_sanitiser_stream DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver checks the word that is taken at this edge. It then decides
  // whether it will stall in the next cycle. Outputs of the block are read in
  // the active region of the edge, so they still hold the values from before
  // the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: the block must move a word on either side before the count of
  // idle cycles passes WATCHDOG_LIMIT. Even a receiver that stalls 79 percent
  // of the time will break this only with a vanishing probability.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offers one word and returns at the edge that accepts it. The sender may
  // idle first. The caller's next drive then lands in the same time step, so
  // s_tvalid gets just one assignment per step.
  task automatic send_word(input logic [7:0] b, input logic end_of_name);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= end_of_name;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.absorb_word(b, end_of_name);
    sent_words++;
  endtask

  // Picks one raw byte. junk_pct sets the share of arbitrary byte values.
  // The remainder is split between text bytes and separators.
  function automatic logic [7:0] random_name_byte(input int junk_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < junk_pct) return 8'($urandom_range(255));
    if (roll < junk_pct + (100 - junk_pct) / 3)
      return ($urandom_range(1) != 0) ? SEP_CHAR : SPACE_CHAR;
    case ($urandom_range(5))
      0:       return 8'($urandom_range(8'h5A, 8'h41));
      1:       return 8'($urandom_range(8'h7A, 8'h61));
      2:       return 8'($urandom_range(8'h39, 8'h30));
      3:       return DASH_CHAR;
      4:       return DOT_CHAR;
      default: return 8'($urandom_range(8'h7A, 8'h61));
    endcase
  endfunction

  // Sends one random name and its closing word. Most names are well formed
  // and short. A few are long, and some are mostly junk. The closing word
  // carries random data, which the block must ignore.
  task automatic send_random_name();
    int len;
    int junk_pct;
    len      = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(10);
    junk_pct = ($urandom_range(6) == 0) ? 70 : 10;
    for (int k = 0; k < len; k++) send_word(random_name_byte(junk_pct), 1'b0);
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  // Sends a fixed string as the bytes of one name, without the closing word.
  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_word(s[k], 1'b0);
  endtask

  // Holds the sender off until the block has given back every owed byte.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent_words    = 0;
    while (sent_words < PHASE_WORDS) send_random_name();
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed names, sent with no idling on the sender side. The first one
    // mixes junk bytes and leading separators with a run of separators
    // between text. It also has every kind of text byte and a trailing
    // separator, which must not show up in the output.
    send_word(8'h00, 1'b0);
    send_text("_ Az _ 09-.");
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("@Z_");
    send_word(8'hFF, 1'b1);
    // An empty name must be answered with the fallback.
    send_word(8'h00, 1'b1);
    // A name made only of separators and junk is empty as well.
    send_text(" ");
    send_word(8'h7F, 1'b0);
    send_text("_");
    send_word(8'h41, 1'b1);
    // A single text byte comes out as the last byte at once.
    send_text("a");
    send_word(8'h00, 1'b1);
    wait_drained();

    run_phase(6, 79);
    run_phase(79, 6);
    run_phase(0, 0);

    // Let any stray output show up before the final verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_words.size() != 0) begin
      $error("%0d expected words never arrived", sb.expected_words.size());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/nss_pkg.sv
design/nss_front.sv
design/nss_queue.sv
design/nss_back.sv
design/name_sanitiser_stream.sv
dv/name_sanitiser_stream_tb.sv
